@@ rtl/core/jst_pkg.sv @@
package jst_pkg;

  localparam int MaxDepth = 32;
  localparam int DepthW   = $clog2(MaxDepth + 1);
  localparam int IdxW     = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;

  typedef enum logic [2:0] {
    PH_BEFORE_OPEN  = 3'd0,
    PH_BEFORE_NAME  = 3'd1,
    PH_AFTER_NAME   = 3'd2,
    PH_BEFORE_VALUE = 3'd3,
    PH_AFTER_VALUE  = 3'd4,
    PH_SCALAR       = 3'd5
  } phase_t;

  localparam logic [4:0] SC_NONE       = 5'd0;
  localparam logic [4:0] SC_NAME       = 5'd1;
  localparam logic [4:0] SC_STR        = 5'd4;
  localparam logic [4:0] SC_SIGN       = 5'd7;
  localparam logic [4:0] SC_INT        = 5'd8;
  localparam logic [4:0] SC_FRACT      = 5'd9;
  localparam logic [4:0] SC_EXP        = 5'd10;
  localparam logic [4:0] SC_EXP_SIGN   = 5'd11;
  localparam logic [4:0] SC_EXP_DIGITS = 5'd12;
  localparam logic [4:0] SC_T_START    = 5'd13;
  localparam logic [4:0] SC_T_END      = 5'd16;
  localparam logic [4:0] SC_F_START    = 5'd17;
  localparam logic [4:0] SC_F_END      = 5'd21;
  localparam logic [4:0] SC_N_START    = 5'd22;
  localparam logic [4:0] SC_N_END      = 5'd25;

  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_OBJ_OPEN  = 4'd1;
  localparam logic [3:0] EV_OBJ_CLOSE = 4'd2;
  localparam logic [3:0] EV_ARR_OPEN  = 4'd3;
  localparam logic [3:0] EV_ARR_CLOSE = 4'd4;
  localparam logic [3:0] EV_NAME      = 4'd5;
  localparam logic [3:0] EV_STRING    = 4'd6;
  localparam logic [3:0] EV_NUMBER    = 4'd7;
  localparam logic [3:0] EV_TRUE      = 4'd8;
  localparam logic [3:0] EV_FALSE     = 4'd9;
  localparam logic [3:0] EV_NULL      = 4'd10;
  localparam logic [3:0] EV_SCALAR    = 4'd11;
  localparam logic [3:0] EV_ERROR     = 4'd12;

  localparam logic [3:0] ER_NONE       = 4'd0;
  localparam logic [3:0] ER_NO_OPENER  = 4'd1;
  localparam logic [3:0] ER_NO_NAME    = 4'd2;
  localparam logic [3:0] ER_NO_COLON   = 4'd3;
  localparam logic [3:0] ER_BAD_START  = 4'd4;
  localparam logic [3:0] ER_BAD_AFTER  = 4'd5;
  localparam logic [3:0] ER_BAD_ESCAPE = 4'd6;
  localparam logic [3:0] ER_BAD_UNI    = 4'd7;
  localparam logic [3:0] ER_BAD_NUMBER = 4'd8;
  localparam logic [3:0] ER_BAD_LIT    = 4'd9;
  localparam logic [3:0] ER_PREMATURE  = 4'd10;
  localparam logic [3:0] ER_TOO_DEEP   = 4'd11;

  // Up to three events per byte
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][3:0] kind;
    logic [2:0][7:0] data;
    logic [3:0]      err;
  } evset_t;

  function automatic logic [7:0] lit_expect(input logic [4:0] s);
    logic [7:0] r;
    begin
      unique case (s)
        5'd13: r = "r";
        5'd14: r = "u";
        5'd15: r = "e";
        5'd17: r = "a";
        5'd18: r = "l";
        5'd19: r = "s";
        5'd20: r = "e";
        5'd22: r = "u";
        5'd23: r = "l";
        5'd24: r = "l";
        default: r = 8'd0;
      endcase
      return r;
    end
  endfunction

endpackage

@@ rtl/core/jst_out_queue.sv @@
// Holds up to three events of one byte and hands them out one per transaction.
module jst_out_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  jst_pkg::evset_t            ev,
  input  logic [jst_pkg::DepthW-1:0] depth,
  input  logic [23:0]                line,
  input  logic [15:0]                col,
  input  logic                       done,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [3:0]                 out_event_kind,
  output logic [7:0]                 out_event_data,
  output logic [3:0]                 out_error_code,
  output logic [5:0]                 out_nest_depth,
  output logic [23:0]                out_line_number,
  output logic [15:0]                out_column_number,
  output logic                       out_document_done,
  output logic                       out_last_of_run
);

  logic [1:0]                 cnt_r, pos_r;
  jst_pkg::evset_t            ev_r;
  logic [jst_pkg::DepthW-1:0] depth_r;
  logic [23:0]                line_r;
  logic [15:0]                col_r;
  logic                       done_r;
  logic                       take, last;

  assign out_valid = (cnt_r != 2'd0);
  assign take      = out_valid && !out_stall;
  assign last      = (pos_r + 2'd1 == cnt_r);
  // free for a new byte if empty or its last event leaves now
  assign busy      = out_valid && !(take && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      pos_r <= 2'd0;
    end else if (load) begin
      cnt_r <= ev.count;
      pos_r <= 2'd0;
    end else if (take) begin
      if (last) cnt_r <= 2'd0;
      else pos_r <= pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_r    <= ev;
      depth_r <= depth;
      line_r  <= line;
      col_r   <= col;
      done_r  <= done;
    end
  end

  always_comb begin
    out_event_kind    = ev_r.kind[pos_r];
    out_event_data    = ev_r.data[pos_r];
    out_error_code    = (ev_r.kind[pos_r] == jst_pkg::EV_ERROR) ? ev_r.err : jst_pkg::ER_NONE;
    out_nest_depth    = 6'(depth_r);
    out_line_number   = line_r;
    out_column_number = col_r;
    out_document_done = done_r;
    out_last_of_run   = last;
  end

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pos_r < cnt_r) else $error("queue position past count");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !busy) else $error("byte loaded over pending events");
  a_empty_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (take && last && !load) |=> !out_valid) else $error("queue not drained");
`endif

endmodule

@@ rtl/core/json_stream_tokenizer_unit.sv @@
// JSON stream tokenizer: takes one byte of JSON text per transaction, one every cycle unless
// in_stall holds it, and emits one to three result transactions per byte (token events,
// decoded name or string bytes, UTF-8 from \u escapes, errors) with row, column and depth.
// A new byte is taken in the cycle in which the last result of the previous byte leaves,
// so a byte that yields several results holds the next byte back until they have all left;
// the three-entry output queue sets this. After an error or the root closing, bytes are
// consumed silently. Nesting depth is bounded by jst_pkg::MaxDepth.
module json_stream_tokenizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_event_kind,
  output logic [7:0]  out_event_data,
  output logic [3:0]  out_error_code,
  output logic [5:0]  out_nest_depth,
  output logic [23:0] out_line_number,
  output logic [15:0] out_column_number,
  output logic        out_document_done,
  output logic        out_last_of_run
);

  localparam int DW = jst_pkg::DepthW;
  localparam int IW = jst_pkg::IdxW;

  logic                     top_kind_r;
  logic [jst_pkg::MaxDepth-1:0] stack_r, stack_nxt;
  logic [DW-1:0]            depth_r, depth_nxt;
  jst_pkg::phase_t          phase_r, phase_nxt;
  logic [4:0]               sc_r, sc_nxt;
  logic [15:0]              uni_r, uni_nxt;
  logic [2:0]               hexc_r, hexc_nxt;
  logic [23:0]              line_r, line_nxt;
  logic [15:0]              col_r, col_nxt;
  logic                     err_r, closed_r, closed_nxt;

  logic            busy, accept, silent, load;
  jst_pkg::evset_t ev;
  logic [3:0]      fc;
  logic [7:0]      c;
  logic            topk, sp, dig, term, hexok;
  logic [3:0]      hv;
  logic [15:0]     cp;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign silent   = err_r || closed_r;
  assign load     = accept && !silent;
  assign c        = in_text_byte;

  always_comb begin
    topk  = (depth_r == '0 || depth_r > DW'(jst_pkg::MaxDepth)) ? 1'b0
          : stack_r[IW'(depth_r - DW'(1))];
    sp    = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    dig   = (c >= "0" && c <= "9");
    term  = sp || c == "," || c == "]" || c == "}";
    hexok = 1'b1;
    hv    = 4'd0;
    if (dig) hv = 4'(c - "0");
    else if (c >= "a" && c <= "f") hv = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") hv = 4'(c - "A" + 8'd10);
    else hexok = 1'b0;
  end

  // Per-byte transition; events collected in order, capped at three
  always_comb begin : step
    logic [4:0]   sub, base;
    logic [3:0]   sk;
    logic [7:0]   d;
    logic         doesc, dopush, dopop, pushk, dofollow;
    ev         = '0;
    fc         = jst_pkg::ER_NONE;
    stack_nxt  = stack_r;
    depth_nxt  = depth_r;
    phase_nxt  = phase_r;
    sc_nxt     = sc_r;
    uni_nxt    = uni_r;
    hexc_nxt   = hexc_r;
    closed_nxt = closed_r;
    sub = 5'd0; base = 5'd0; sk = 4'd0; d = 8'd0;
    doesc = 1'b0; dopush = 1'b0; dopop = 1'b0; pushk = 1'b0; dofollow = 1'b0;
    cp = 16'd0;

    unique case (phase_r)
      jst_pkg::PH_BEFORE_OPEN: begin
        if (c == (top_kind_r ? 8'h5B : 8'h7B)) begin dopush = 1'b1; pushk = top_kind_r; end
        else if (!sp) fc = jst_pkg::ER_NO_OPENER;
      end
      jst_pkg::PH_BEFORE_NAME: begin
        if (c == 8'h22) begin phase_nxt = jst_pkg::PH_SCALAR; sc_nxt = jst_pkg::SC_NAME; end
        else if (c == "}") dopop = 1'b1;
        else if (!sp) fc = jst_pkg::ER_NO_NAME;
      end
      jst_pkg::PH_AFTER_NAME: begin
        if (c == ":") phase_nxt = jst_pkg::PH_BEFORE_VALUE;
        else if (!sp) fc = jst_pkg::ER_NO_COLON;
      end
      jst_pkg::PH_BEFORE_VALUE: begin
        if (!sp) begin
          phase_nxt = jst_pkg::PH_SCALAR;
          if (dig || c == "+" || c == "-" || c == ".") begin
            sc_nxt = dig ? jst_pkg::SC_INT : (c == "." ? jst_pkg::SC_FRACT : jst_pkg::SC_SIGN);
            ev.count = 2'd1; ev.kind[0] = jst_pkg::EV_NUMBER; ev.data[0] = c;
          end else if (c == 8'h22) sc_nxt = jst_pkg::SC_STR;
          else if (c == "t") sc_nxt = jst_pkg::SC_T_START;
          else if (c == "f") sc_nxt = jst_pkg::SC_F_START;
          else if (c == "n") sc_nxt = jst_pkg::SC_N_START;
          else if (c == "{") begin dopush = 1'b1; pushk = 1'b0; end
          else if (c == "[") begin dopush = 1'b1; pushk = 1'b1; end
          else if (c == "]" && topk) dopop = 1'b1;
          else begin phase_nxt = jst_pkg::PH_BEFORE_VALUE; fc = jst_pkg::ER_BAD_START; end
        end
      end
      jst_pkg::PH_AFTER_VALUE: begin
        dofollow = (c == "," || (!topk && c == "}") || (topk && c == "]"));
        if (!dofollow && !sp) fc = jst_pkg::ER_BAD_AFTER;
      end
      jst_pkg::PH_SCALAR: begin
        if (sc_r >= jst_pkg::SC_NAME && sc_r < jst_pkg::SC_SIGN) begin
          base = (sc_r < jst_pkg::SC_STR) ? jst_pkg::SC_NAME : jst_pkg::SC_STR;
          sk   = (sc_r < jst_pkg::SC_STR) ? jst_pkg::EV_NAME : jst_pkg::EV_STRING;
          sub  = sc_r - base;
          if (sub == 5'd0) begin
            if (c == 8'h22) begin
              sc_nxt = jst_pkg::SC_NONE;
              if (base == jst_pkg::SC_NAME) phase_nxt = jst_pkg::PH_AFTER_NAME;
              else begin
                phase_nxt = jst_pkg::PH_AFTER_VALUE;
                ev.count = 2'd1; ev.kind[0] = jst_pkg::EV_SCALAR;
              end
            end else if (c == 8'h5C) sc_nxt = base + 5'd1;
            else begin ev.count = 2'd1; ev.kind[0] = sk; ev.data[0] = c; end
          end else if (sub == 5'd1) begin
            sc_nxt = base;
            doesc  = 1'b1;
            unique case (c)
              8'h22, 8'h5C, 8'h2F, 8'h27: d = c;
              "b": d = 8'd8;
              "f": d = 8'd12;
              "n": d = 8'd10;
              "r": d = 8'd13;
              "t": d = 8'd9;
              "u": begin
                doesc = 1'b0; sc_nxt = base + 5'd2; uni_nxt = 16'd0; hexc_nxt = 3'd0;
              end
              default: begin doesc = 1'b0; sc_nxt = sc_r; fc = jst_pkg::ER_BAD_ESCAPE; end
            endcase
            if (doesc) begin ev.count = 2'd1; ev.kind[0] = sk; ev.data[0] = d; end
          end else begin
            if (!hexok) fc = jst_pkg::ER_BAD_UNI;
            else begin
              cp       = {uni_r[11:0], hv};
              uni_nxt  = cp;
              hexc_nxt = hexc_r + 3'd1;
              if (hexc_r + 3'd1 >= 3'd4) begin
                hexc_nxt = 3'd0;
                sc_nxt   = base;
                ev.kind  = {sk, sk, sk};
                if (cp < 16'h80) begin
                  ev.count = 2'd1; ev.data[0] = cp[7:0];
                end else if (cp < 16'h800) begin
                  ev.count = 2'd2;
                  ev.data[0] = {3'b110, cp[10:6]};
                  ev.data[1] = {2'b10, cp[5:0]};
                end else begin
                  ev.count = 2'd3;
                  ev.data[0] = {4'b1110, cp[15:12]};
                  ev.data[1] = {2'b10, cp[11:6]};
                  ev.data[2] = {2'b10, cp[5:0]};
                end
              end
            end
          end
        end else if (sc_r >= jst_pkg::SC_SIGN && sc_r <= jst_pkg::SC_EXP_DIGITS) begin
          ev.count = 2'd1; ev.kind[0] = jst_pkg::EV_NUMBER; ev.data[0] = c;
          priority if (sc_r == jst_pkg::SC_SIGN) begin
            if (dig) sc_nxt = jst_pkg::SC_INT;
            else if (c == ".") sc_nxt = jst_pkg::SC_FRACT;
            else fc = jst_pkg::ER_BAD_NUMBER;
          end else if (sc_r == jst_pkg::SC_INT || sc_r == jst_pkg::SC_FRACT) begin
            if (dig) sc_nxt = sc_r;
            else if (c == "." && sc_r == jst_pkg::SC_INT) sc_nxt = jst_pkg::SC_FRACT;
            else if (c == "e" || c == "E") sc_nxt = jst_pkg::SC_EXP;
            else if (term) begin ev.kind[0] = jst_pkg::EV_SCALAR; ev.data[0] = 8'd0;
              dofollow = 1'b1; end
            else fc = jst_pkg::ER_BAD_NUMBER;
          end else if (sc_r == jst_pkg::SC_EXP) begin
            if (c == "+" || c == "-") sc_nxt = jst_pkg::SC_EXP_SIGN;
            else if (dig) sc_nxt = jst_pkg::SC_EXP_DIGITS;
            else fc = jst_pkg::ER_BAD_NUMBER;
          end else if (sc_r == jst_pkg::SC_EXP_SIGN) begin
            if (dig) sc_nxt = jst_pkg::SC_EXP_DIGITS;
            else fc = jst_pkg::ER_BAD_NUMBER;
          end else begin
            if (term) begin ev.kind[0] = jst_pkg::EV_SCALAR; ev.data[0] = 8'd0;
              dofollow = 1'b1; end
            else if (!dig) fc = jst_pkg::ER_BAD_NUMBER;
          end
        end else if (sc_r > jst_pkg::SC_EXP_DIGITS && sc_r <= jst_pkg::SC_N_END) begin
          if (sc_r == jst_pkg::SC_T_END || sc_r == jst_pkg::SC_F_END
              || sc_r == jst_pkg::SC_N_END) begin
            if (term) begin
              ev.count = 2'd1; ev.kind[0] = jst_pkg::EV_SCALAR; dofollow = 1'b1;
            end else fc = jst_pkg::ER_BAD_LIT;
          end else if (c != jst_pkg::lit_expect(sc_r)) fc = jst_pkg::ER_BAD_LIT;
          else begin
            sc_nxt = sc_r + 5'd1;
            if (sc_r + 5'd1 == jst_pkg::SC_T_END) begin
              ev.count = 2'd1; ev.kind[0] = jst_pkg::EV_TRUE; end
            else if (sc_r + 5'd1 == jst_pkg::SC_F_END) begin
              ev.count = 2'd1; ev.kind[0] = jst_pkg::EV_FALSE; end
            else if (sc_r + 5'd1 == jst_pkg::SC_N_END) begin
              ev.count = 2'd1; ev.kind[0] = jst_pkg::EV_NULL; end
          end
        end else fc = jst_pkg::ER_BAD_START;
      end
      default: fc = jst_pkg::ER_BAD_START;
    endcase

    if (dofollow) begin
      sc_nxt = jst_pkg::SC_NONE;
      if (c == ",") phase_nxt = topk ? jst_pkg::PH_BEFORE_VALUE : jst_pkg::PH_BEFORE_NAME;
      else if ((!topk && c == "}") || (topk && c == "]")) dopop = 1'b1;
      else phase_nxt = jst_pkg::PH_AFTER_VALUE;
    end

    if (dopush) begin
      if (depth_r >= DW'(jst_pkg::MaxDepth)) fc = jst_pkg::ER_TOO_DEEP;
      else begin
        stack_nxt[IW'(depth_r)] = pushk;
        depth_nxt = depth_r + DW'(1);
        sc_nxt    = jst_pkg::SC_NONE;
        phase_nxt = pushk ? jst_pkg::PH_BEFORE_VALUE : jst_pkg::PH_BEFORE_NAME;
        ev.count  = 2'd1;
        ev.kind[0] = pushk ? jst_pkg::EV_ARR_OPEN : jst_pkg::EV_OBJ_OPEN;
        ev.data[0] = 8'd0;
      end
    end

    if (dopop) begin
      depth_nxt = (depth_r != '0) ? depth_r - DW'(1) : depth_r;
      ev.kind[ev.count] = topk ? jst_pkg::EV_ARR_CLOSE : jst_pkg::EV_OBJ_CLOSE;
      ev.data[ev.count] = 8'd0;
      ev.count = ev.count + 2'd1;
      sc_nxt   = jst_pkg::SC_NONE;
      if (depth_nxt == '0) closed_nxt = 1'b1;
      else phase_nxt = jst_pkg::PH_AFTER_VALUE;
    end

    if (fc == jst_pkg::ER_NONE && in_end_of_text && !closed_nxt) fc = jst_pkg::ER_PREMATURE;
    if (fc != jst_pkg::ER_NONE) begin
      ev = '0;
      ev.count = 2'd1; ev.kind[0] = jst_pkg::EV_ERROR; ev.err = fc;
    end else if (ev.count == 2'd0) begin
      ev.count = 2'd1;
    end
  end

  always_comb begin
    col_nxt  = (col_r < 16'hFFFF) ? col_r + 16'd1 : col_r;
    line_nxt = line_r;
    if (c == 8'h0A) begin
      col_nxt = 16'd0;
      if (line_r < 24'hFFFFFF) line_nxt = line_r + 24'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_kind_r <= 1'b0;
      stack_r    <= '0;
      depth_r    <= '0;
      phase_r    <= jst_pkg::PH_BEFORE_OPEN;
      sc_r       <= jst_pkg::SC_NONE;
      uni_r      <= 16'd0;
      hexc_r     <= 3'd0;
      line_r     <= 24'd0;
      col_r      <= 16'd0;
      err_r      <= 1'b0;
      closed_r   <= 1'b0;
    end else begin
      if (cfg_we) top_kind_r <= cfg_wdata;
      if (load) begin
        line_r <= line_nxt;
        col_r  <= col_nxt;
        if (fc != jst_pkg::ER_NONE) err_r <= 1'b1;
        // an error leaves the rest of the state as it was; it is never used again
        else begin
          stack_r  <= stack_nxt;
          depth_r  <= depth_nxt;
          phase_r  <= phase_nxt;
          sc_r     <= sc_nxt;
          uni_r    <= uni_nxt;
          hexc_r   <= hexc_nxt;
          closed_r <= closed_nxt;
        end
      end
    end
  end

  // depth and done after the byte: a premature end still reports the depth it reached
  jst_out_queue u_queue (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (load),
    .ev                (ev),
    .depth             (depth_nxt),
    .line              (line_nxt),
    .col               (col_nxt),
    .done              (closed_nxt),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_event_data    (out_event_data),
    .out_error_code    (out_error_code),
    .out_nest_depth    (out_nest_depth),
    .out_line_number   (out_line_number),
    .out_column_number (out_column_number),
    .out_document_done (out_document_done),
    .out_last_of_run   (out_last_of_run)
  );

  logic unused_req;
  assign unused_req = in_req_type;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(jst_pkg::MaxDepth)) else $error("depth past stack size");
  a_sticky_err: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r) else $error("error flag cleared");
  a_silent_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    silent |=> $stable(col_r) && $stable(line_r)) else $error("position moved when silent");
  a_closed_depth: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |-> depth_r == '0) else $error("closed with open depth");
`endif

endmodule

@@ bench/json_stream_tokenizer_unit_tb.sv @@
module json_stream_tokenizer_unit_tb;

  localparam logic [7:0] QUOTE  = 8'h22;
  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] LF     = 8'h0A;
  localparam int STALL_LIMIT    = 2000;

  typedef struct {
    logic [7:0] b;
    bit         eot;
  } text_item_t;

  typedef struct {
    logic [7:0] b;
    bit         known;
    logic [3:0] kind;
  } opening_row_t;

  typedef struct {
    logic [3:0]  kind;
    logic [7:0]  data;
    logic [3:0]  err;
    logic [5:0]  depth;
    logic [23:0] line;
    logic [15:0] col;
    logic        done;
    logic        last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_req_type = 1'b0;
  logic [7:0]  in_text_byte = 8'd0;
  logic        in_end_of_text = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [3:0]  out_event_kind;
  logic [7:0]  out_event_data;
  logic [3:0]  out_error_code;
  logic [5:0]  out_nest_depth;
  logic [23:0] out_line_number;
  logic [15:0] out_column_number;
  logic        out_document_done;
  logic        out_last_of_run;

  json_stream_tokenizer_unit uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_text_byte(in_text_byte), .in_end_of_text(in_end_of_text),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_event_kind(out_event_kind), .out_event_data(out_event_data),
    .out_error_code(out_error_code), .out_nest_depth(out_nest_depth),
    .out_line_number(out_line_number), .out_column_number(out_column_number),
    .out_document_done(out_document_done), .out_last_of_run(out_last_of_run)
  );

  always #5 clk = ~clk;

  // Opening document fragment: a signed exponent number, a leading-dot number ended
  // by the wrong closer, and a string with a two-byte \u escape and an escaped apostrophe.
  opening_row_t opening_rows [25] = '{
    '{8'h20, 1'b1, jst_pkg::EV_NONE}, '{"[", 1'b1, jst_pkg::EV_ARR_OPEN},
    '{"-", 1'b1, jst_pkg::EV_NUMBER},
    '{"1", 1'b0, jst_pkg::EV_NONE}, '{".", 1'b0, jst_pkg::EV_NONE},
    '{"5", 1'b0, jst_pkg::EV_NONE}, '{"e", 1'b0, jst_pkg::EV_NONE},
    '{"+", 1'b0, jst_pkg::EV_NONE}, '{"3", 1'b0, jst_pkg::EV_NONE},
    '{",", 1'b1, jst_pkg::EV_SCALAR}, '{".", 1'b1, jst_pkg::EV_NUMBER},
    '{"5", 1'b0, jst_pkg::EV_NONE}, '{"}", 1'b1, jst_pkg::EV_SCALAR},
    '{",", 1'b1, jst_pkg::EV_NONE}, '{QUOTE, 1'b1, jst_pkg::EV_NONE},
    '{BSLASH, 1'b1, jst_pkg::EV_NONE}, '{"u", 1'b1, jst_pkg::EV_NONE},
    '{"0", 1'b1, jst_pkg::EV_NONE}, '{"0", 1'b1, jst_pkg::EV_NONE},
    '{"e", 1'b1, jst_pkg::EV_NONE}, '{"9", 1'b1, jst_pkg::EV_STRING},
    '{BSLASH, 1'b1, jst_pkg::EV_NONE}, '{"'", 1'b1, jst_pkg::EV_STRING},
    '{QUOTE, 1'b1, jst_pkg::EV_SCALAR}, '{",", 1'b1, jst_pkg::EV_NONE}
  };

  // Tokenizer state as predicted
  logic            tk_root;
  logic            tk_stack [jst_pkg::MaxDepth];
  int              tk_depth;
  jst_pkg::phase_t tk_phase;
  logic [4:0]      tk_scalar;
  logic [15:0]     tk_uni;
  int              tk_hexn;
  logic [23:0]     tk_line;
  logic [15:0]     tk_col;
  bit              tk_err;
  bit              tk_closed;
  logic [3:0]      ev_kind [3];
  logic [7:0]      ev_data [3];
  int              ev_n;
  logic [3:0]      fault;

  token_t      pending_tokens [$];
  text_item_t  doc_q [$];
  int          fail_count = 0;
  int          got_n = 0;
  int          sent_n = 0;
  int          quiet_cycles = 0;
  bit          deep_done = 0;

  function automatic void note(input logic [3:0] k, input logic [7:0] d);
    if (ev_n < 3) begin
      ev_kind[ev_n] = k;
      ev_data[ev_n] = d;
      ev_n++;
    end
  endfunction

  function automatic void flag(input logic [3:0] code);
    if (fault == jst_pkg::ER_NONE) fault = code;
  endfunction

  function automatic bit is_ws(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_term(input logic [7:0] c);
    return is_ws(c) || c == "," || c == "]" || c == "}";
  endfunction

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic logic [7:0] spelled_next(input logic [4:0] s);
    case (s)
      5'd13: return "r";
      5'd14: return "u";
      5'd15: return "e";
      5'd17: return "a";
      5'd18: return "l";
      5'd19: return "s";
      5'd20: return "e";
      5'd22: return "u";
      5'd23: return "l";
      5'd24: return "l";
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic top_kind();
    if (tk_depth == 0) return 1'b0;
    return tk_stack[tk_depth-1];
  endfunction

  function automatic void open_container(input logic k);
    if (tk_depth >= jst_pkg::MaxDepth) begin
      flag(jst_pkg::ER_TOO_DEEP);
      return;
    end
    tk_stack[tk_depth] = k;
    tk_depth++;
    tk_scalar = jst_pkg::SC_NONE;
    tk_phase = k ? jst_pkg::PH_BEFORE_VALUE : jst_pkg::PH_BEFORE_NAME;
    note(k ? jst_pkg::EV_ARR_OPEN : jst_pkg::EV_OBJ_OPEN, 8'd0);
  endfunction

  function automatic void close_container();
    logic k;
    k = top_kind();
    if (tk_depth > 0) tk_depth--;
    note(k ? jst_pkg::EV_ARR_CLOSE : jst_pkg::EV_OBJ_CLOSE, 8'd0);
    tk_scalar = jst_pkg::SC_NONE;
    if (tk_depth == 0) tk_closed = 1;
    else tk_phase = jst_pkg::PH_AFTER_VALUE;
  endfunction

  // The byte that ends a scalar also acts as the container's next byte
  function automatic void after_scalar(input logic [7:0] c);
    logic k;
    k = top_kind();
    tk_scalar = jst_pkg::SC_NONE;
    if (c == ",") tk_phase = k ? jst_pkg::PH_BEFORE_VALUE : jst_pkg::PH_BEFORE_NAME;
    else if ((!k && c == "}") || (k && c == "]")) close_container();
    else tk_phase = jst_pkg::PH_AFTER_VALUE;
  endfunction

  function automatic void utf8_out(input logic [3:0] k, input logic [15:0] cp);
    if (cp < 16'h80) begin
      note(k, cp[7:0]);
    end else if (cp < 16'h800) begin
      note(k, {3'b110, cp[10:6]});
      note(k, {2'b10, cp[5:0]});
    end else begin
      note(k, {4'hE, cp[15:12]});
      note(k, {2'b10, cp[11:6]});
      note(k, {2'b10, cp[5:0]});
    end
  endfunction

  function automatic void string_step(input logic [7:0] c, input logic [4:0] base);
    logic [4:0] sub;
    logic [3:0] k;
    logic [7:0] d;
    int         h;
    sub = tk_scalar - base;
    k = (base == jst_pkg::SC_NAME) ? jst_pkg::EV_NAME : jst_pkg::EV_STRING;
    d = c;
    if (sub == 0) begin
      if (c == QUOTE) begin
        tk_scalar = jst_pkg::SC_NONE;
        if (base == jst_pkg::SC_NAME) begin
          tk_phase = jst_pkg::PH_AFTER_NAME;
        end else begin
          tk_phase = jst_pkg::PH_AFTER_VALUE;
          note(jst_pkg::EV_SCALAR, 8'd0);
        end
      end else if (c == BSLASH) begin
        tk_scalar = base + 5'd1;
      end else begin
        note(k, c);
      end
    end else if (sub == 1) begin
      tk_scalar = base;
      case (c)
        QUOTE, BSLASH, "/", "'": d = c;
        "b": d = 8'd8;
        "f": d = 8'd12;
        "n": d = 8'd10;
        "r": d = 8'd13;
        "t": d = 8'd9;
        "u": begin
          tk_scalar = base + 5'd2;
          tk_uni = 16'd0;
          tk_hexn = 0;
          return;
        end
        default: begin
          flag(jst_pkg::ER_BAD_ESCAPE);
          return;
        end
      endcase
      note(k, d);
    end else begin
      h = hex_val(c);
      if (h < 0) begin
        flag(jst_pkg::ER_BAD_UNI);
        return;
      end
      tk_uni = {tk_uni[11:0], h[3:0]};
      tk_hexn++;
      if (tk_hexn >= 4) begin
        utf8_out(k, tk_uni);
        tk_hexn = 0;
        tk_scalar = base;
      end
    end
  endfunction

  function automatic void number_step(input logic [7:0] c);
    logic [4:0] s;
    bit         dig;
    s = tk_scalar;
    dig = is_dig(c);
    if (s == jst_pkg::SC_SIGN) begin
      if (dig) tk_scalar = jst_pkg::SC_INT;
      else if (c == ".") tk_scalar = jst_pkg::SC_FRACT;
      else begin
        flag(jst_pkg::ER_BAD_NUMBER);
        return;
      end
    end else if (s == jst_pkg::SC_INT || s == jst_pkg::SC_FRACT) begin
      if (dig) begin
      end else if (c == "." && s == jst_pkg::SC_INT) tk_scalar = jst_pkg::SC_FRACT;
      else if (c == "e" || c == "E") tk_scalar = jst_pkg::SC_EXP;
      else if (is_term(c)) begin
        note(jst_pkg::EV_SCALAR, 8'd0);
        after_scalar(c);
        return;
      end else begin
        flag(jst_pkg::ER_BAD_NUMBER);
        return;
      end
    end else if (s == jst_pkg::SC_EXP) begin
      if (c == "+" || c == "-") tk_scalar = jst_pkg::SC_EXP_SIGN;
      else if (dig) tk_scalar = jst_pkg::SC_EXP_DIGITS;
      else begin
        flag(jst_pkg::ER_BAD_NUMBER);
        return;
      end
    end else if (s == jst_pkg::SC_EXP_SIGN) begin
      if (dig) tk_scalar = jst_pkg::SC_EXP_DIGITS;
      else begin
        flag(jst_pkg::ER_BAD_NUMBER);
        return;
      end
    end else begin
      if (is_term(c)) begin
        note(jst_pkg::EV_SCALAR, 8'd0);
        after_scalar(c);
        return;
      end
      if (!dig) begin
        flag(jst_pkg::ER_BAD_NUMBER);
        return;
      end
    end
    note(jst_pkg::EV_NUMBER, c);
  endfunction

  function automatic void literal_step(input logic [7:0] c);
    logic [4:0] s;
    s = tk_scalar;
    if (s == jst_pkg::SC_T_END || s == jst_pkg::SC_F_END || s == jst_pkg::SC_N_END) begin
      if (is_term(c)) begin
        note(jst_pkg::EV_SCALAR, 8'd0);
        after_scalar(c);
      end else begin
        flag(jst_pkg::ER_BAD_LIT);
      end
      return;
    end
    if (s >= 5'd26 || c != spelled_next(s)) begin
      flag(jst_pkg::ER_BAD_LIT);
      return;
    end
    tk_scalar = s + 5'd1;
    if (tk_scalar == jst_pkg::SC_T_END) note(jst_pkg::EV_TRUE, 8'd0);
    else if (tk_scalar == jst_pkg::SC_F_END) note(jst_pkg::EV_FALSE, 8'd0);
    else if (tk_scalar == jst_pkg::SC_N_END) note(jst_pkg::EV_NULL, 8'd0);
  endfunction

  function automatic void value_start(input logic [7:0] c);
    logic k;
    k = top_kind();
    if (is_ws(c)) return;
    tk_phase = jst_pkg::PH_SCALAR;
    if (is_dig(c) || c == "+" || c == "-" || c == ".") begin
      tk_scalar = is_dig(c) ? jst_pkg::SC_INT
                : (c == "." ? jst_pkg::SC_FRACT : jst_pkg::SC_SIGN);
      note(jst_pkg::EV_NUMBER, c);
    end else if (c == QUOTE) tk_scalar = jst_pkg::SC_STR;
    else if (c == "t") tk_scalar = jst_pkg::SC_T_START;
    else if (c == "f") tk_scalar = jst_pkg::SC_F_START;
    else if (c == "n") tk_scalar = jst_pkg::SC_N_START;
    else if (c == "{") open_container(1'b0);
    else if (c == "[") open_container(1'b1);
    else if (c == "]" && k) close_container();
    else begin
      tk_phase = jst_pkg::PH_BEFORE_VALUE;
      flag(jst_pkg::ER_BAD_START);
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] c);
    logic k;
    k = top_kind();
    case (tk_phase)
      jst_pkg::PH_BEFORE_OPEN: begin
        if (c == (tk_root ? "[" : "{")) open_container(tk_root);
        else if (!is_ws(c)) flag(jst_pkg::ER_NO_OPENER);
      end
      jst_pkg::PH_BEFORE_NAME: begin
        if (c == QUOTE) begin
          tk_phase = jst_pkg::PH_SCALAR;
          tk_scalar = jst_pkg::SC_NAME;
        end else if (c == "}") close_container();
        else if (!is_ws(c)) flag(jst_pkg::ER_NO_NAME);
      end
      jst_pkg::PH_AFTER_NAME: begin
        if (c == ":") tk_phase = jst_pkg::PH_BEFORE_VALUE;
        else if (!is_ws(c)) flag(jst_pkg::ER_NO_COLON);
      end
      jst_pkg::PH_BEFORE_VALUE: value_start(c);
      jst_pkg::PH_AFTER_VALUE: begin
        if (c == ",") tk_phase = k ? jst_pkg::PH_BEFORE_VALUE : jst_pkg::PH_BEFORE_NAME;
        else if ((!k && c == "}") || (k && c == "]")) close_container();
        else if (!is_ws(c)) flag(jst_pkg::ER_BAD_AFTER);
      end
      default: begin
        if (tk_scalar >= jst_pkg::SC_NAME && tk_scalar < jst_pkg::SC_STR)
          string_step(c, jst_pkg::SC_NAME);
        else if (tk_scalar >= jst_pkg::SC_STR && tk_scalar < jst_pkg::SC_SIGN)
          string_step(c, jst_pkg::SC_STR);
        else if (tk_scalar >= jst_pkg::SC_SIGN && tk_scalar <= jst_pkg::SC_EXP_DIGITS)
          number_step(c);
        else if (tk_scalar > jst_pkg::SC_EXP_DIGITS && tk_scalar <= jst_pkg::SC_N_END)
          literal_step(c);
        else flag(jst_pkg::ER_BAD_START);
      end
    endcase
  endfunction

  // Queue the tokens one accepted byte gives; returns how many
  function automatic int predict_tokens(input logic [7:0] c, input bit eot);
    token_t t;
    if (tk_err || tk_closed) return 0;
    if (tk_col < 16'hFFFF) tk_col++;
    if (c == LF) begin
      tk_col = 16'd0;
      if (tk_line < 24'hFFFFFF) tk_line++;
    end
    ev_n = 0;
    fault = jst_pkg::ER_NONE;
    parse_byte(c);
    if (fault == jst_pkg::ER_NONE && eot && !tk_closed) flag(jst_pkg::ER_PREMATURE);
    if (fault != jst_pkg::ER_NONE) begin
      tk_err = 1;
      ev_n = 1;
      ev_kind[0] = jst_pkg::EV_ERROR;
      ev_data[0] = 8'd0;
    end else if (ev_n == 0) begin
      ev_n = 1;
      ev_kind[0] = jst_pkg::EV_NONE;
      ev_data[0] = 8'd0;
    end
    for (int k = 0; k < ev_n; k++) begin
      t.kind = ev_kind[k];
      t.data = ev_data[k];
      t.err = (ev_kind[k] == jst_pkg::EV_ERROR) ? fault : jst_pkg::ER_NONE;
      t.depth = tk_depth[5:0];
      t.line = tk_line;
      t.col = tk_col;
      t.done = tk_closed;
      t.last = (k == ev_n - 1);
      pending_tokens = {pending_tokens, t};
    end
    return ev_n;
  endfunction

  // Document generator
  function automatic void put(input logic [7:0] b, input bit eot = 0);
    text_item_t it;
    it.b = b;
    it.eot = eot;
    doc_q = {doc_q, it};
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_ws();
    int n;
    logic [7:0] pick [4] = '{8'h20, LF, 8'h09, 8'h0D};
    n = $urandom_range(0, 2);
    repeat (n) put(pick[$urandom_range(0, 3)]);
  endfunction

  function automatic void put_digits(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) put(8'("0" + $urandom_range(0, 9)));
  endfunction

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  function automatic void put_number();
    int lead;
    lead = $urandom_range(0, 4);
    if (lead == 1) put("-");
    if (lead == 2) put("+");
    if (lead == 3) begin
      put(".");
      put_digits(1, 3);
    end else begin
      put_digits(1, 3);
      if ($urandom_range(0, 2) == 0) begin
        put(".");
        put_digits(1, 2);
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      put($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0: put("+");
        1: put("-");
        default: ;
      endcase
      put_digits(1, 2);
    end
  endfunction

  function automatic void put_string();
    int         cp;
    logic [7:0] b;
    string      esc = "\"\\/'bfnrt";
    put(QUOTE);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          do b = 8'($urandom_range(0, 255)); while (b == QUOTE || b == BSLASH);
          put(b);
        end
        2: begin
          put(BSLASH);
          put(esc[$urandom_range(0, esc.len() - 1)]);
        end
        default: begin
          case ($urandom_range(0, 2))
            0: cp = $urandom_range(0, 16'h7F);
            1: cp = $urandom_range(16'h80, 16'h7FF);
            default: cp = $urandom_range(16'h800, 16'hFFFF);
          endcase
          put(BSLASH);
          put("u");
          for (int s = 12; s >= 0; s -= 4) put(hex_char((cp >> s) & 15));
        end
      endcase
    end
    put(QUOTE);
  endfunction

  // Returns 1 where the value still needs a terminating byte
  function automatic bit put_value(input int level);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        put_number();
        return 1;
      end
      3, 4: put_string();
      5, 6: begin
        case ($urandom_range(0, 2))
          0: put_str("true");
          1: put_str("false");
          default: put_str("null");
        endcase
        return 1;
      end
      7: begin
        if (level >= 4) put_string();
        else put_object(level + 1);
      end
      8: begin
        if (level >= 4) put_string();
        else put_array(level + 1);
      end
      default: begin
        if (!deep_done && level == 1) begin
          // climb to one below the depth limit and back
          deep_done = 1;
          repeat (jst_pkg::MaxDepth - 2) put("[");
          repeat (jst_pkg::MaxDepth - 2) put("]");
        end else begin
          put_number();
          return 1;
        end
      end
    endcase
    return 0;
  endfunction

  function automatic void put_array(input int level);
    int n;
    n = $urandom_range(0, 3);
    put("[");
    put_ws();
    for (int i = 0; i < n; i++) begin
      // the wrong closer may end a bare scalar
      if (put_value(level) && $urandom_range(0, 5) == 0) put("}");
      put_ws();
      if (i < n - 1 || $urandom_range(0, 3) == 0) begin
        put(",");
        put_ws();
      end
    end
    put("]");
  endfunction

  function automatic void put_object(input int level);
    int n;
    n = $urandom_range(0, 3);
    put("{");
    put_ws();
    for (int i = 0; i < n; i++) begin
      put_string();
      put_ws();
      put(":");
      put_ws();
      if (put_value(level) && $urandom_range(0, 5) == 0) put("]");
      put_ws();
      if (i < n - 1 || $urandom_range(0, 3) == 0) begin
        put(",");
        put_ws();
      end
    end
    put("}");
  endfunction

  // Body of the root array, then one way of ending the document
  function automatic void build_document();
    void'(put_value(1));
    while (doc_q.size() < 200) begin
      put_ws();
      put(",");
      put_ws();
      void'(put_value(1));
    end
    case ($urandom_range(0, 10))
      0: put("]", 1);
      1: put(8'h20, 1);
      2: put_str(",#");
      3: put_str(",{x");
      4: put_str(",{\"a\" x");
      5: put_str(" x");
      6: put_str(",\"\\q");
      7: put_str(",\"\\u0g");
      8: put_str(",1x");
      9: put_str(",tx");
      default: begin
        put(",");
        repeat (jst_pkg::MaxDepth) put("[");
      end
    endcase
    // everything after this is dropped by the block
    repeat (8) put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endfunction

  task automatic write_root(input logic v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    tk_root = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic offer(input logic [7:0] b, input bit eot, input bit known,
                       input logic [3:0] kind);
    int n;
    if ((sent_n < 120 || sent_n >= 170) && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= 1'($urandom_range(0, 1));
    in_text_byte <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_n++;
    n = predict_tokens(b, eot);
    if (known && n > 0 && pending_tokens[pending_tokens.size() - n].kind != kind) begin
      $display("%0t: opening byte %h: expected kind %0d, predicted %0d", $time, b, kind,
               pending_tokens[pending_tokens.size() - n].kind);
      fail_count++;
    end
  endtask

  task automatic drain();
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    tk_root = 1'b0;
    foreach (tk_stack[i]) tk_stack[i] = 1'b0;
    tk_depth = 0;
    tk_phase = jst_pkg::PH_BEFORE_OPEN;
    tk_scalar = jst_pkg::SC_NONE;
    tk_uni = 16'd0;
    tk_hexn = 0;
    tk_line = 24'd0;
    tk_col = 16'd0;
    tk_err = 0;
    tk_closed = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_root(1'b1);
    write_root(1'b0);
    write_root(1'b1);
    foreach (opening_rows[i])
      offer(opening_rows[i].b, 1'b0, opening_rows[i].known, opening_rows[i].kind);
    in_valid <= 1'b0;
    drain();
    write_root(1'($urandom_range(0, 1)));
    build_document();
    foreach (doc_q[i]) offer(doc_q[i].b, doc_q[i].eot, 1'b0, jst_pkg::EV_NONE);
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_tokens.size() == 0)
      $display("json_stream_tokenizer_unit test passed");
    else
      $display("json_stream_tokenizer_unit test failed");
    $finish;
  end

  // Result side: random stalls, one long hold-off, and a quiet stretch
  int  hold_left = 0;
  bit  held = 0;
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (got_n >= 50 && !held) begin
      held <= 1;
      hold_left <= 150;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (got_n >= 90 && got_n < 170) ? 1'b0 : ($urandom_range(0, 99) < 18);
    end
  end

  always @(posedge clk) begin
    token_t t;
    if (rst_n && out_valid && !out_stall) begin
      got_n <= got_n + 1;
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected transaction, kind %0d", $time, out_event_kind);
        fail_count++;
      end else begin
        t = pending_tokens.pop_front();
        if (t.kind !== out_event_kind || t.data !== out_event_data ||
            t.err !== out_error_code || t.depth !== out_nest_depth ||
            t.line !== out_line_number || t.col !== out_column_number ||
            t.done !== out_document_done || t.last !== out_last_of_run) begin
          $display("%0t: mismatch expected kind %0d data %h err %0d depth %0d",
                   $time, t.kind, t.data, t.err, t.depth,
                   " line %0d col %0d done %b last %b",
                   t.line, t.col, t.done, t.last);
          $display("%0t:            actual kind %0d data %h err %0d depth %0d",
                   $time, out_event_kind, out_event_data, out_error_code, out_nest_depth,
                   " line %0d col %0d done %b last %b",
                   out_line_number, out_column_number, out_document_done,
                   out_last_of_run);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("json_stream_tokenizer_unit test failed");
        $finish;
      end
    end
  end

endmodule
